// ===== rtl/rpv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rpv_pkg;

	// Packet framing constants
	localparam int MAX_PACKET_BYTES = 4096;
	localparam int HDR_BYTES        = 20;
	localparam int ATTR_HDR         = 2;
	localparam int AUTH_BYTES       = 16;
	localparam int EAP_MIN_VALUE    = 4;
	localparam int MIN_BUFFER       = 4;
	localparam logic [16:0] OFFSET_MAX = 17'h1FFFF;
	localparam logic [11:0] COUNT_MAX  = 12'hFFF;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_MIN_LEN   = 2'd0,
		CFG_MAX_LEN   = 2'd1,
		CFG_MSGAUTH   = 2'd2,
		CFG_EAP_TYPE  = 2'd3
	} cfg_index_t;

	// Result status codes
	typedef enum logic [3:0] {
		STAT_OK            = 4'd0,
		STAT_SHORT         = 4'd1,
		STAT_LEN_RANGE     = 4'd2,
		STAT_LEN_MISMATCH  = 4'd3,
		STAT_ATTR_SHORT    = 4'd4,
		STAT_ATTR_OVERRUN  = 4'd5,
		STAT_DUP_MSGAUTH   = 4'd6,
		STAT_MSGAUTH_SIZE  = 4'd7,
		STAT_NOT_FILLED    = 4'd8,
		STAT_EAP_FIRST     = 4'd9,
		STAT_EAP_EMPTY     = 4'd10,
		STAT_EAP_SUM       = 4'd11
	} status_t;

	typedef struct packed {
		logic [15:0] min_packet_length;
		logic [15:0] max_packet_length;
		logic [7:0]  msg_auth_type;
		logic [7:0]  eap_message_type;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} rpv_in_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [7:0]  packet_code;
		logic [7:0]  packet_id;
		logic [15:0] packet_length;
		logic [11:0] attribute_count;
		logic        msgauth_present;
		logic [11:0] msgauth_value_offset;
		logic [15:0] eap_declared_length;
	} rpv_out_t;

endpackage

`default_nettype wire

// ===== rtl/rpv_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rpv_cfg_regs (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [15:0]         cfg_data,
	output rpv_pkg::cfg_t            cfg
);

	rpv_pkg::cfg_t cfg_q;

	// Write the addressed register, reset to the standard type codes and bounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_packet_length <= 16'd20;
			cfg_q.max_packet_length <= 16'd4096;
			cfg_q.msg_auth_type     <= 8'd80;
			cfg_q.eap_message_type  <= 8'd79;
		end else if (cfg_we) begin
			unique case (rpv_pkg::cfg_index_t'(cfg_index))
				rpv_pkg::CFG_MIN_LEN:  cfg_q.min_packet_length <= cfg_data;
				rpv_pkg::CFG_MAX_LEN:  cfg_q.max_packet_length <= cfg_data;
				rpv_pkg::CFG_MSGAUTH:  cfg_q.msg_auth_type     <= cfg_data[7:0];
				rpv_pkg::CFG_EAP_TYPE: cfg_q.eap_message_type  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/rpv_walker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rpv_walker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire rpv_pkg::rpv_in_t    item,
	input  wire rpv_pkg::cfg_t       cfg,
	output rpv_pkg::rpv_out_t        result
);

	// Packet state
	logic [16:0]      byte_offset_q, byte_offset_d;
	logic [7:0]       hdr_code_q, hdr_code_d;
	logic [7:0]       hdr_id_q, hdr_id_d;
	logic [15:0]      hdr_len_q, hdr_len_d;
	logic [16:0]      next_attr_q, next_attr_d;
	logic [7:0]       attr_type_q, attr_type_d;
	logic             attr_is_eap_q, attr_is_eap_d;
	rpv_pkg::status_t attr_err_q, attr_err_d;
	logic             stopped_q, stopped_d;
	logic             ma_seen_q, ma_seen_d;
	logic [11:0]      ma_off_q, ma_off_d;
	logic [11:0]      attr_cnt_q, attr_cnt_d;
	logic [11:0]      eap_cnt_q, eap_cnt_d;
	logic [2:0]       eap_pos_q, eap_pos_d;
	logic [15:0]      eap_len_q, eap_len_d;
	logic [16:0]      eap_sum_q, eap_sum_d;
	logic             eap_short_q, eap_short_d;
	logic             eap_empty_q, eap_empty_d;

	logic [7:0]       b;
	logic [17:0]      next_p1, next_p2, attr_end, sum_ext;
	logic [7:0]       vlen;
	logic             ma_fail;
	logic             eap_ok;
	rpv_pkg::status_t stat;

	assign b       = item.data_byte;
	assign next_p1 = {1'b0, next_attr_q} + 18'd1;
	assign next_p2 = {1'b0, next_attr_q} + 18'(rpv_pkg::ATTR_HDR);
	assign attr_end = {1'b0, next_attr_q} + {10'd0, b};
	assign vlen    = b - 8'(rpv_pkg::ATTR_HDR);
	assign sum_ext = {1'b0, eap_sum_q} + {10'd0, vlen};

	// Advance the header latch and the attribute walk by one byte
	always_comb begin
		byte_offset_d = byte_offset_q;
		hdr_code_d    = hdr_code_q;
		hdr_id_d      = hdr_id_q;
		hdr_len_d     = hdr_len_q;
		next_attr_d   = next_attr_q;
		attr_type_d   = attr_type_q;
		attr_is_eap_d = attr_is_eap_q;
		attr_err_d    = attr_err_q;
		stopped_d     = stopped_q;
		ma_seen_d     = ma_seen_q;
		ma_off_d      = ma_off_q;
		attr_cnt_d    = attr_cnt_q;
		eap_cnt_d     = eap_cnt_q;
		eap_pos_d     = eap_pos_q;
		eap_len_d     = eap_len_q;
		eap_sum_d     = eap_sum_q;
		eap_short_d   = eap_short_q;
		eap_empty_d   = eap_empty_q;
		ma_fail       = 1'b0;

		case (byte_offset_q)
			17'd0: hdr_code_d = b;
			17'd1: hdr_id_d   = b;
			17'd2: hdr_len_d  = {b, 8'h00};
			17'd3: hdr_len_d  = {hdr_len_q[15:8], b};
			default: ;
		endcase

		if (!stopped_q && byte_offset_q >= 17'(rpv_pkg::HDR_BYTES)) begin
			if (byte_offset_q == next_attr_q) begin
				// Type byte: stop quietly when the attribute header does not fit
				if (next_p2 > {2'b00, hdr_len_q}) begin
					stopped_d = 1'b1;
				end else begin
					attr_type_d   = b;
					attr_is_eap_d = 1'b0;
				end
			end else if ({1'b0, byte_offset_q} == next_p1) begin
				// Length byte: run the attribute checks
				if (b < 8'(rpv_pkg::ATTR_HDR)) begin
					attr_err_d = rpv_pkg::STAT_ATTR_SHORT;
					stopped_d  = 1'b1;
				end else if (attr_end > {2'b00, hdr_len_q}) begin
					attr_err_d = rpv_pkg::STAT_ATTR_OVERRUN;
					stopped_d  = 1'b1;
				end else begin
					if (attr_type_q == cfg.msg_auth_type) begin
						if (ma_seen_q) begin
							attr_err_d = rpv_pkg::STAT_DUP_MSGAUTH;
							stopped_d  = 1'b1;
							ma_fail    = 1'b1;
						end else if (b != 8'(rpv_pkg::AUTH_BYTES + rpv_pkg::ATTR_HDR)) begin
							attr_err_d = rpv_pkg::STAT_MSGAUTH_SIZE;
							stopped_d  = 1'b1;
							ma_fail    = 1'b1;
						end else begin
							ma_seen_d = 1'b1;
							ma_off_d  = next_attr_q[11:0] + 12'(rpv_pkg::ATTR_HDR);
						end
					end
					if (!ma_fail) begin
						if (attr_type_q == cfg.eap_message_type) begin
							if (eap_cnt_q == 12'd0) begin
								if (vlen < 8'(rpv_pkg::EAP_MIN_VALUE)) begin
									eap_short_d = 1'b1;
								end else begin
									attr_is_eap_d = 1'b1;
									eap_pos_d     = 3'd0;
								end
							end
							if (vlen == 8'd0) begin
								eap_empty_d = 1'b1;
							end
							eap_sum_d = (sum_ext > {1'b0, rpv_pkg::OFFSET_MAX}) ?
								rpv_pkg::OFFSET_MAX : sum_ext[16:0];
							if (eap_cnt_q != rpv_pkg::COUNT_MAX) begin
								eap_cnt_d = eap_cnt_q + 12'd1;
							end
						end
						if (attr_cnt_q != rpv_pkg::COUNT_MAX) begin
							attr_cnt_d = attr_cnt_q + 12'd1;
						end
						next_attr_d = attr_end[16:0];
					end
				end
			end else if (attr_is_eap_q) begin
				// Value byte of the first EAP fragment: pick up the EAP length
				if (eap_pos_q == 3'd2) begin
					eap_len_d = {b, 8'h00};
				end else if (eap_pos_q == 3'd3) begin
					eap_len_d = {eap_len_q[15:8], b};
				end
				if (eap_pos_q != 3'd7) begin
					eap_pos_d = eap_pos_q + 3'd1;
				end
			end
		end

		if (byte_offset_q != rpv_pkg::OFFSET_MAX) begin
			byte_offset_d = byte_offset_q + 17'd1;
		end
	end

	// Rank the checks on the state as it stands after this byte
	always_comb begin
		eap_ok = (eap_cnt_d != 12'd0) && !eap_short_d;
		if (byte_offset_d < 17'(rpv_pkg::MIN_BUFFER)) begin
			stat = rpv_pkg::STAT_SHORT;
		end else if (hdr_len_d < cfg.min_packet_length || hdr_len_d > cfg.max_packet_length ||
				{1'b0, hdr_len_d} > 17'(rpv_pkg::MAX_PACKET_BYTES)) begin
			stat = rpv_pkg::STAT_LEN_RANGE;
		end else if (byte_offset_d != {1'b0, hdr_len_d}) begin
			stat = rpv_pkg::STAT_LEN_MISMATCH;
		end else if (attr_err_d != rpv_pkg::STAT_OK) begin
			stat = attr_err_d;
		end else if (next_attr_d != {1'b0, hdr_len_d}) begin
			stat = rpv_pkg::STAT_NOT_FILLED;
		end else if (eap_cnt_d != 12'd0 && eap_short_d) begin
			stat = rpv_pkg::STAT_EAP_FIRST;
		end else if (eap_cnt_d != 12'd0 && eap_empty_d) begin
			stat = rpv_pkg::STAT_EAP_EMPTY;
		end else if (eap_cnt_d != 12'd0 && eap_sum_d != {1'b0, eap_len_d}) begin
			stat = rpv_pkg::STAT_EAP_SUM;
		end else begin
			stat = rpv_pkg::STAT_OK;
		end

		result.status               = stat;
		result.packet_code          = hdr_code_d;
		result.packet_id            = hdr_id_d;
		result.packet_length        = hdr_len_d;
		result.attribute_count      = attr_cnt_d;
		result.msgauth_present      = ma_seen_d;
		result.msgauth_value_offset = ma_seen_d ? ma_off_d : 12'd0;
		result.eap_declared_length  = eap_ok ? eap_len_d : 16'd0;
	end

	// Update the packet state; clear it after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q <= '0;
			hdr_code_q    <= '0;
			hdr_id_q      <= '0;
			hdr_len_q     <= '0;
			next_attr_q   <= 17'(rpv_pkg::HDR_BYTES);
			attr_type_q   <= '0;
			attr_is_eap_q <= 1'b0;
			attr_err_q    <= rpv_pkg::STAT_OK;
			stopped_q     <= 1'b0;
			ma_seen_q     <= 1'b0;
			ma_off_q      <= '0;
			attr_cnt_q    <= '0;
			eap_cnt_q     <= '0;
			eap_pos_q     <= '0;
			eap_len_q     <= '0;
			eap_sum_q     <= '0;
			eap_short_q   <= 1'b0;
			eap_empty_q   <= 1'b0;
		end else if (step) begin
			if (item.end_of_buffer) begin
				byte_offset_q <= '0;
				hdr_code_q    <= '0;
				hdr_id_q      <= '0;
				hdr_len_q     <= '0;
				next_attr_q   <= 17'(rpv_pkg::HDR_BYTES);
				attr_type_q   <= '0;
				attr_is_eap_q <= 1'b0;
				attr_err_q    <= rpv_pkg::STAT_OK;
				stopped_q     <= 1'b0;
				ma_seen_q     <= 1'b0;
				ma_off_q      <= '0;
				attr_cnt_q    <= '0;
				eap_cnt_q     <= '0;
				eap_pos_q     <= '0;
				eap_len_q     <= '0;
				eap_sum_q     <= '0;
				eap_short_q   <= 1'b0;
				eap_empty_q   <= 1'b0;
			end else begin
				byte_offset_q <= byte_offset_d;
				hdr_code_q    <= hdr_code_d;
				hdr_id_q      <= hdr_id_d;
				hdr_len_q     <= hdr_len_d;
				next_attr_q   <= next_attr_d;
				attr_type_q   <= attr_type_d;
				attr_is_eap_q <= attr_is_eap_d;
				attr_err_q    <= attr_err_d;
				stopped_q     <= stopped_d;
				ma_seen_q     <= ma_seen_d;
				ma_off_q      <= ma_off_d;
				attr_cnt_q    <= attr_cnt_d;
				eap_cnt_q     <= eap_cnt_d;
				eap_pos_q     <= eap_pos_d;
				eap_len_q     <= eap_len_d;
				eap_sum_q     <= eap_sum_d;
				eap_short_q   <= eap_short_d;
				eap_empty_q   <= eap_empty_d;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/radius_packet_validator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// RADIUS packet structure checker. Feed the packet one byte per transaction in
// buffer order and mark the last byte with end_of_buffer; that byte produces one
// result transaction carrying the status (first error wins, length errors
// first) and the header, attribute, Message-Authenticator and EAP facts. Other
// bytes produce nothing. Throughput is one byte per clock while no last byte is
// stalled: each byte passes an input register, then compare-and-add logic
// updates the walk state and, on the last byte, loads the result register. Input
// backpressure only occurs when a last byte waits behind an untaken result. The
// packet state clears itself after each last byte. Configuration writes take
// effect at once; the user must make them only while no packet is in flight,
// which the block does not enforce. Authenticator signing is not done here.
module radius_packet_validator (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [15:0]          cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire rpv_pkg::rpv_in_t     in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output rpv_pkg::rpv_out_t         out_data
);

	rpv_pkg::cfg_t     cfg;
	rpv_pkg::rpv_in_t  in_s1;
	logic              in_valid_s1;
	rpv_pkg::rpv_out_t res_s2;
	rpv_pkg::rpv_out_t walk_res;
	logic              res_valid_s2;
	logic              out_free;
	logic              step;

	rpv_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Process the held byte unless it is a last byte facing a full result slot
	assign out_free = !res_valid_s2 || out_ready;
	assign step     = in_valid_s1 && (!in_s1.end_of_buffer || out_free);
	assign in_ready = !in_valid_s1 || step;

	rpv_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (in_s1),
		.cfg    (cfg),
		.result (walk_res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (out_free) begin
			res_valid_s2 <= step && in_s1.end_of_buffer;
		end
	end

	always_ff @(posedge clk) begin
		if (step && in_s1.end_of_buffer) begin
			res_s2 <= walk_res;
		end
	end

	assign out_valid = res_valid_s2;
	assign out_data  = res_s2;

	// A new result only ever follows a processed last byte
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_s2) |-> $past(step && in_s1.end_of_buffer))
		else $error("result appeared without a last byte");

	// A held byte that cannot advance stays put
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !step) |=> (in_valid_s1 && $stable(in_s1)))
		else $error("held byte lost or changed");

	// Offset is reported only with a found Message-Authenticator
	a_msgauth_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.msgauth_present) |-> (out_data.msgauth_value_offset == 12'd0))
		else $error("offset without Message-Authenticator");

	// A too-short buffer never reaches the attribute walk
	a_short_no_attr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == rpv_pkg::STAT_SHORT) |->
		(out_data.attribute_count == 12'd0))
		else $error("attributes counted in short buffer");

endmodule

`default_nettype wire

// ===== test/radius_packet_validator_tb.sv =====
`timescale 1ns / 1ps

module radius_packet_validator_tb;

	import rpv_pkg::*;

	localparam logic [15:0] RESET_MIN_LEN      = 16'd20;
	localparam logic [15:0] RESET_MAX_LEN      = 16'd4096;
	localparam logic [7:0]  RESET_MSGAUTH_TYPE = 8'd80;
	localparam logic [7:0]  RESET_EAP_TYPE     = 8'd79;
	localparam logic [7:0]  USER_NAME_TYPE     = 8'd1;
	localparam logic [7:0]  MSGAUTH_ATTR_LEN   = 8'd18;
	localparam int          IDLE_PERCENT       = 11;
	localparam int          CYCLE_LIMIT        = 1_000_000;

	// Tracks one packet as it streams in and predicts the verdict on its last byte
	class radius_tracker;
		logic [15:0] min_len, max_len;
		logic [7:0]  auth_type, eap_type;

		int unsigned offset, next_attr, eap_sum, attr_count, frag_count, eap_pos;
		logic [7:0]  hdr_code, hdr_id, cur_type;
		logic [15:0] hdr_len, eap_len;
		logic [11:0] auth_off;
		bit          cur_eap, stopped, auth_seen, first_short, empty_seen;
		status_t     attr_err;

		rpv_out_t expected_verdicts[$];
		int       errors;

		function new();
			min_len = RESET_MIN_LEN;
			max_len = RESET_MAX_LEN;
			auth_type = RESET_MSGAUTH_TYPE;
			eap_type = RESET_EAP_TYPE;
			errors = 0;
			clear_packet();
		endfunction

		function void clear_packet();
			offset = 0;
			hdr_code = '0;
			hdr_id = '0;
			hdr_len = '0;
			next_attr = HDR_BYTES;
			cur_type = '0;
			cur_eap = 0;
			attr_err = STAT_OK;
			stopped = 0;
			auth_seen = 0;
			auth_off = '0;
			attr_count = 0;
			frag_count = 0;
			eap_pos = 0;
			eap_len = '0;
			eap_sum = 0;
			first_short = 0;
			empty_seen = 0;
		endfunction

		function void set_reg(cfg_index_t idx, logic [15:0] value);
			case (idx)
				CFG_MIN_LEN:  min_len = value;
				CFG_MAX_LEN:  max_len = value;
				CFG_MSGAUTH:  auth_type = value[7:0];
				CFG_EAP_TYPE: eap_type = value[7:0];
				default: ;
			endcase
		endfunction

		function void stop_walk(status_t s);
			attr_err = s;
			stopped = 1;
		endfunction

		function int pending();
			return expected_verdicts.size();
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			int unsigned o, start, len, vlen;
			status_t     st;
			rpv_out_t    r;
			o = offset;

			// latch header fields
			case (o)
				0: hdr_code = b;
				1: hdr_id = b;
				2: hdr_len = {b, 8'h00};
				3: hdr_len[7:0] = b;
				default: ;
			endcase

			// walk attributes
			if (!stopped && o >= HDR_BYTES) begin
				if (o == next_attr) begin
					if (next_attr + ATTR_HDR > hdr_len) begin
						stopped = 1;
					end else begin
						cur_type = b;
						cur_eap = 0;
					end
				end else if (o == next_attr + 1) begin
					start = next_attr;
					len = b;
					if (len < ATTR_HDR) begin
						stop_walk(STAT_ATTR_SHORT);
					end else if (start + len > hdr_len) begin
						stop_walk(STAT_ATTR_OVERRUN);
					end else if (cur_type == auth_type && auth_seen) begin
						stop_walk(STAT_DUP_MSGAUTH);
					end else if (cur_type == auth_type && len != AUTH_BYTES + ATTR_HDR) begin
						stop_walk(STAT_MSGAUTH_SIZE);
					end else begin
						if (cur_type == auth_type) begin
							auth_seen = 1;
							auth_off = 12'(start + ATTR_HDR);
						end
						vlen = len - ATTR_HDR;
						if (cur_type == eap_type) begin
							if (frag_count == 0) begin
								if (vlen < EAP_MIN_VALUE) begin
									first_short = 1;
								end else begin
									cur_eap = 1;
									eap_pos = 0;
								end
							end
							if (vlen == 0) empty_seen = 1;
							eap_sum += vlen;
							if (eap_sum > OFFSET_MAX) eap_sum = OFFSET_MAX;
							if (frag_count < COUNT_MAX) frag_count++;
						end
						if (attr_count < COUNT_MAX) attr_count++;
						next_attr = start + len;
					end
				end else if (cur_eap) begin
					// pick the EAP length out of the first fragment
					if (eap_pos == 2) eap_len = {b, 8'h00};
					else if (eap_pos == 3) eap_len[7:0] = b;
					if (eap_pos < 7) eap_pos++;
				end
			end

			if (offset < OFFSET_MAX) offset++;
			if (!last) return;

			// first failing check wins
			if (offset < MIN_BUFFER) st = STAT_SHORT;
			else if (hdr_len < min_len || hdr_len > max_len || hdr_len > MAX_PACKET_BYTES)
				st = STAT_LEN_RANGE;
			else if (offset != hdr_len) st = STAT_LEN_MISMATCH;
			else if (attr_err != STAT_OK) st = attr_err;
			else if (next_attr != hdr_len) st = STAT_NOT_FILLED;
			else if (frag_count != 0 && first_short) st = STAT_EAP_FIRST;
			else if (frag_count != 0 && empty_seen) st = STAT_EAP_EMPTY;
			else if (frag_count != 0 && eap_sum != eap_len) st = STAT_EAP_SUM;
			else st = STAT_OK;

			r.status = st;
			r.packet_code = hdr_code;
			r.packet_id = hdr_id;
			r.packet_length = hdr_len;
			r.attribute_count = 12'(attr_count);
			r.msgauth_present = auth_seen;
			r.msgauth_value_offset = auth_seen ? auth_off : 12'h000;
			r.eap_declared_length = (frag_count != 0 && !first_short) ? eap_len : 16'h0000;
			expected_verdicts.push_back(r);
			clear_packet();
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(rpv_out_t got);
			rpv_out_t want;
			if (expected_verdicts.size() == 0) begin
				$error("result transaction with no packet pending, status %0d", got.status);
				errors++;
				return;
			end
			want = expected_verdicts.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("packet_code", want.packet_code, got.packet_code);
			compare_field("packet_id", want.packet_id, got.packet_id);
			compare_field("packet_length", want.packet_length, got.packet_length);
			compare_field("attribute_count", want.attribute_count, got.attribute_count);
			compare_field("msgauth_present", want.msgauth_present, got.msgauth_present);
			compare_field("msgauth_value_offset", want.msgauth_value_offset,
				got.msgauth_value_offset);
			compare_field("eap_declared_length", want.eap_declared_length,
				got.eap_declared_length);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	cfg_index_t cfg_index = CFG_MIN_LEN;
	logic [15:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	rpv_in_t    in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	rpv_out_t   out_data;

	radius_tracker sb = new();
	logic [7:0]    pkt[$];
	int unsigned   bytes_sent = 0;
	int unsigned   cycles = 0;
	bit            calm = 0;

	radius_packet_validator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Bound the run
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[radius_packet_validator] ERROR");
		$finish;
	end

	// Check result transactions and stall the result side at random
	initial begin
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) sb.check_result(out_data);
			out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	// Packet building
	function automatic void start_packet();
		pkt.delete();
		repeat (HDR_BYTES) pkt.push_back(8'($urandom));
	endfunction

	function automatic void set_word(int unsigned at, logic [15:0] value);
		pkt[at] = value[15:8];
		pkt[at + 1] = value[7:0];
	endfunction

	function automatic void set_length();
		set_word(2, 16'(pkt.size()));
	endfunction

	function automatic void add_attr(logic [7:0] kind, logic [7:0] len);
		pkt.push_back(kind);
		pkt.push_back(len);
		for (int i = ATTR_HDR; i < len; i++) pkt.push_back(8'($urandom));
	endfunction

	// Append an EAP-Message fragment; return where its value starts
	function automatic int unsigned add_eap(int unsigned vlen);
		add_attr(sb.eap_type, 8'(vlen + ATTR_HDR));
		return pkt.size() - vlen;
	endfunction

	// Mostly well-formed packets with random content, some broken on purpose
	function automatic void rand_packet();
		int unsigned n_attr, eap_at, eap_total, vlen, at;
		bit          eap_started, auth_added;
		start_packet();
		n_attr = $urandom_range(0, 6);
		eap_started = 0;
		auth_added = 0;
		eap_total = 0;
		eap_at = 0;
		for (int i = 0; i < n_attr; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: add_attr(8'($urandom), 8'($urandom_range(2, 12)));
				4, 5: begin
					if (auth_added) begin
						add_attr(USER_NAME_TYPE, 8'($urandom_range(2, 12)));
					end else begin
						add_attr(sb.auth_type, MSGAUTH_ATTR_LEN);
						auth_added = 1;
					end
				end
				default: begin
					if (!eap_started) begin
						vlen = $urandom_range(4, 12);
						eap_at = add_eap(vlen);
						eap_started = 1;
					end else begin
						vlen = $urandom_range(1, 10);
						void'(add_eap(vlen));
					end
					eap_total += vlen;
				end
			endcase
		end
		if (eap_started)
			set_word(eap_at + 2, ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(eap_total));
		set_length();

		if ($urandom_range(0, 99) < 30) begin
			case ($urandom_range(0, 9))
				0: if (pkt.size() > 1) void'(pkt.pop_back());
				1: pkt.push_back(8'($urandom));
				2: set_word(2, $urandom_range(0, 1) ? 16'(pkt.size() + 1) : 16'(pkt.size() - 1));
				3: begin
					add_attr(8'($urandom), 8'($urandom_range(0, 1)));
					set_length();
				end
				4: begin
					at = pkt.size();
					add_attr(8'($urandom), 8'd4);
					set_length();
					pkt[at + 1] = 8'($urandom_range(5, 255));
				end
				5: begin
					add_attr(sb.auth_type, MSGAUTH_ATTR_LEN);
					add_attr(sb.auth_type, $urandom_range(0, 1) ? MSGAUTH_ATTR_LEN :
						8'($urandom_range(2, 30)));
					set_length();
				end
				6: begin
					vlen = $urandom_range(2, 30);
					if (vlen == MSGAUTH_ATTR_LEN) vlen++;
					add_attr(sb.auth_type, 8'(vlen));
					set_length();
				end
				7: begin
					add_attr(sb.eap_type, 8'($urandom_range(2, 5)));
					set_length();
				end
				8: begin
					pkt.delete();
					repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
				end
				default: begin
					pkt.push_back(8'($urandom));
					set_length();
				end
			endcase
		end
	endfunction

	// Stimulus driving
	task automatic push_byte(logic [7:0] b, logic last);
		while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_byte: b, end_of_buffer: last};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_packet();
		for (int i = 0; i < pkt.size(); i++) push_byte(pkt[i], i == pkt.size() - 1);
	endtask

	// Drop valid and wait for every verdict plus the pipeline tail
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.set_reg(idx, value);
	endtask

	task automatic program_regs(logic [15:0] lo, logic [15:0] hi, logic [7:0] auth,
		logic [7:0] eap);
		write_reg(CFG_MIN_LEN, lo);
		write_reg(CFG_MAX_LEN, hi);
		write_reg(CFG_MSGAUTH, {8'h00, auth});
		write_reg(CFG_EAP_TYPE, {8'h00, eap});
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(int unsigned byte_goal);
		int unsigned base;
		base = bytes_sent;
		while (bytes_sent - base < byte_goal) begin
			rand_packet();
			send_packet();
		end
		drain();
	endtask

	initial begin
		int unsigned at;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// buffers too short to hold a length
		pkt = '{8'hFF};
		send_packet();
		pkt = '{8'h00, 8'hFF, 8'hA5};
		send_packet();

		// length out of range, low and high
		start_packet();
		pkt = pkt[0:3];
		set_length();
		send_packet();
		start_packet();
		set_word(2, 16'hFFFF);
		send_packet();

		// all-zero and all-one headers
		pkt.delete();
		repeat (HDR_BYTES) pkt.push_back(8'h00);
		send_packet();
		pkt.delete();
		repeat (HDR_BYTES) pkt.push_back(8'hFF);
		send_packet();

		// header only, then one byte too many
		start_packet();
		set_length();
		send_packet();
		start_packet();
		set_length();
		pkt.push_back(8'h5A);
		send_packet();

		// attribute length of zero and one
		start_packet();
		add_attr(USER_NAME_TYPE, 8'd0);
		set_length();
		send_packet();
		start_packet();
		add_attr(USER_NAME_TYPE, 8'd1);
		set_length();
		send_packet();

		// attribute runs past the header length
		start_packet();
		add_attr(USER_NAME_TYPE, 8'd6);
		set_length();
		pkt[HDR_BYTES + 1] = 8'd9;
		send_packet();

		// Message-Authenticator: good, duplicated, duplicated and wrongly sized, wrong size
		start_packet();
		add_attr(sb.auth_type, MSGAUTH_ATTR_LEN);
		set_length();
		send_packet();
		start_packet();
		add_attr(sb.auth_type, MSGAUTH_ATTR_LEN);
		add_attr(sb.auth_type, MSGAUTH_ATTR_LEN);
		set_length();
		send_packet();
		start_packet();
		add_attr(sb.auth_type, MSGAUTH_ATTR_LEN);
		add_attr(sb.auth_type, 8'd10);
		set_length();
		send_packet();
		start_packet();
		add_attr(sb.auth_type, 8'd17);
		set_length();
		send_packet();

		// leftover byte too short for an attribute header
		start_packet();
		add_attr(USER_NAME_TYPE, 8'd4);
		pkt.push_back(8'h00);
		set_length();
		send_packet();

		// EAP: good, first fragment short, empty fragment, wrong sum
		start_packet();
		at = add_eap(6);
		set_word(at + 2, 16'(6 + 3));
		void'(add_eap(3));
		set_length();
		send_packet();
		start_packet();
		void'(add_eap(3));
		set_length();
		send_packet();
		start_packet();
		at = add_eap(4);
		set_word(at + 2, 16'd4);
		void'(add_eap(0));
		set_length();
		send_packet();
		start_packet();
		at = add_eap(5);
		set_word(at + 2, 16'd7);
		set_length();
		send_packet();
		drain();

		// random packets under several register settings
		random_phase(150);
		calm = 1;
		random_phase(150);
		calm = 0;
		program_regs(16'h0000, 16'hFFFF, 8'h00, 8'hFF);
		random_phase(150);
		program_regs(RESET_MIN_LEN, RESET_MAX_LEN, RESET_EAP_TYPE, RESET_EAP_TYPE);
		random_phase(150);
		program_regs(16'hFFFF, 16'h0000, 8'hFF, 8'h00);
		random_phase(80);
		program_regs(16'd30, 16'd60, RESET_MSGAUTH_TYPE, RESET_EAP_TYPE);
		random_phase(150);

		if (sb.errors == 0) begin
			$display("[radius_packet_validator] OK");
		end else begin
			$display("[radius_packet_validator] ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/rpv_pkg.sv
rtl/rpv_cfg_regs.sv
rtl/rpv_walker.sv
rtl/radius_packet_validator.sv
test/radius_packet_validator_tb.sv
